/* rtl/unified_camera_remap_address_assert.svh */
// Assertion macros for the remap address generator.
// Each macro expects clk and rst to be visible where it is used.
`ifndef UNIFIED_CAMERA_REMAP_ADDRESS_ASSERT_SVH
`define UNIFIED_CAMERA_REMAP_ADDRESS_ASSERT_SVH
`ifndef SYNTHESIS
// Condition holds in the same cycle as the trigger.
`define UCRA_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("ucra: same-cycle check failed");
// Condition holds in the cycle after the trigger.
`define UCRA_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("ucra: next-cycle check failed");
`else
`define UCRA_ASSERT_NOW(lbl, trig, cond)
`define UCRA_ASSERT_NEXT(lbl, trig, cond)
`endif
`endif

/* rtl/ucra_pkg.sv */
`default_nettype none
package ucra_pkg;

  // Field and datapath widths.
  localparam int CRD_W   = 12;   // pixel index
  localparam int PIX_W   = 16;   // Q12.4 coordinate
  localparam int PRD_W   = 48;   // coordinate times inverse focal length
  localparam int NORM_W  = 31;   // Q3.28 magnitude
  localparam int SQ_W    = 62;
  localparam int R2_W    = 35;
  localparam int XI_W    = 17;
  localparam int XSQ_W   = 34;
  localparam int T_W     = 38;
  localparam int ARGK_W  = 36;   // root argument bits kept in the 64-bit radicand
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int COEF_W  = 33;
  localparam int CNUM_W  = 61;
  localparam int CDEN_W  = 36;
  localparam int UPRD_W  = 64;
  localparam int UNP_W   = 40;
  localparam int PRJ_W   = 45;
  localparam int SIZE_W  = 24;
  localparam int COORD_BITS_DEF = 12;

  localparam logic [XSQ_W-1:0] Q32_ONE = 34'h1_0000_0000;
  localparam logic [T_W-1:0]   Q28_ONE = 38'h10000000;

  // Register map.
  typedef enum logic [2:0] {
    REG_PIN_INV_FX = 3'd0,
    REG_PIN_INV_FY = 3'd1,
    REG_PIN_CENTER = 3'd2,
    REG_SRC_FX     = 3'd3,
    REG_SRC_FY     = 3'd4,
    REG_SRC_CENTER = 3'd5,
    REG_MIRROR     = 3'd6,
    REG_SRC_SIZE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]       pin_inv_fx;
    logic [31:0]       pin_inv_fy;
    logic [31:0]       pin_center;
    logic [31:0]       src_fx;
    logic [31:0]       src_fy;
    logic [31:0]       src_center;
    logic [XI_W-1:0]   mirror_offset;
    logic [SIZE_W-1:0] src_size;
  } cfg_t;

  // Values that ride alongside the root and the coefficient division.
  typedef struct packed {
    logic [NORM_W-1:0] xm;
    logic              xn;
    logic [NORM_W-1:0] ym;
    logic              yn;
    logic [R2_W-1:0]   r2;
    logic              bad;
  } side_t;

endpackage
`default_nettype wire

/* rtl/ucra_front.sv */
`default_nettype none
module ucra_front import ucra_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_vld,
  input  logic [CRD_W-1:0]  in_col,
  input  logic [CRD_W-1:0]  in_row,
  output logic              out_vld,
  output logic [ARGK_W-1:0] out_arg,
  output side_t             out_side
);

  logic [7:0] vld;

  logic [XSQ_W-1:0] xi_sq;
  logic [XSQ_W-1:0] xi_d;
  logic             xi_gt;

  logic [PIX_W:0]   dx, dy;
  logic [PIX_W-1:0] s1_xm, s1_ym;
  logic [PRD_W-1:0] s2_px, s2_py;
  logic [PRD_W:0]   rx, ry;
  logic [NORM_W-1:0] s3_xm, s3_ym, s4_xm, s4_ym, s5_xm, s5_ym;
  logic [NORM_W-1:0] s6_xm, s6_ym, s7_xm, s7_ym;
  logic [SQ_W-1:0]  s4_sx, s4_sy;
  logic [SQ_W:0]    ssum;
  logic [R2_W-1:0]  s5_r2, s6_r2, s7_r2;
  logic [52:0]      s6_hi;
  logic [50:0]      s6_lo;
  logic [53:0]      tsum;
  logic [T_W-1:0]   s7_t;
  logic [T_W-1:0]   arg;
  logic             arg_bad;
  logic [7:1]       xn, yn;

  // Mirror offset terms: xi squared and its distance from one.
  always_ff @(posedge clk) begin
    xi_sq <= cfg.mirror_offset * cfg.mirror_offset;
    xi_gt <= xi_sq > Q32_ONE;
    xi_d  <= (xi_sq > Q32_ONE) ? xi_sq - Q32_ONE : Q32_ONE - xi_sq;
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:0], in_vld};
    end
  end
  assign out_vld = vld[7];

  // Centre the destination coordinate.
  assign dx = {1'b0, in_col, 4'b0} - {1'b0, cfg.pin_center[15:0]};
  assign dy = {1'b0, in_row, 4'b0} - {1'b0, cfg.pin_center[31:16]};

  // Round the scaled coordinate and clamp it to Q3.28.
  assign rx = {1'b0, s2_px} + (PRD_W+1)'(128);
  assign ry = {1'b0, s2_py} + (PRD_W+1)'(128);

  assign ssum = {1'b0, s4_sx} + {1'b0, s4_sy};
  assign tsum = {1'b0, s6_hi} + 54'(s6_lo[50:16]);

  // Root argument: one plus or minus the scaled radius term.
  always_comb begin
    if (xi_gt) begin
      arg_bad = s7_t > Q28_ONE;
      arg     = Q28_ONE - s7_t;
    end else begin
      arg_bad = 1'b0;
      arg     = Q28_ONE + s7_t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_xm <= dx[PIX_W] ? PIX_W'(-dx) : dx[PIX_W-1:0];
      s1_ym <= dy[PIX_W] ? PIX_W'(-dy) : dy[PIX_W-1:0];
      xn[1] <= dx[PIX_W];
      yn[1] <= dy[PIX_W];
      s2_px <= s1_xm * cfg.pin_inv_fx;
      s2_py <= s1_ym * cfg.pin_inv_fy;
      s3_xm <= (|rx[PRD_W:NORM_W+8]) ? '1 : rx[NORM_W+7:8];
      s3_ym <= (|ry[PRD_W:NORM_W+8]) ? '1 : ry[NORM_W+7:8];
      s4_sx <= s3_xm * s3_xm;
      s4_sy <= s3_ym * s3_ym;
      s4_xm <= s3_xm;
      s4_ym <= s3_ym;
      s5_r2 <= ssum[SQ_W:28];
      s5_xm <= s4_xm;
      s5_ym <= s4_ym;
      s6_hi <= xi_d[XSQ_W-1:16] * s5_r2;
      s6_lo <= xi_d[15:0] * s5_r2;
      s6_r2 <= s5_r2;
      s6_xm <= s5_xm;
      s6_ym <= s5_ym;
      s7_t  <= tsum[53:16];
      s7_r2 <= s6_r2;
      s7_xm <= s6_xm;
      s7_ym <= s6_ym;
      xn[7:2] <= xn[6:1];
      yn[7:2] <= yn[6:1];
      out_arg       <= arg[ARGK_W-1:0];
      out_side.xm   <= s7_xm;
      out_side.xn   <= xn[7];
      out_side.ym   <= s7_ym;
      out_side.yn   <= yn[7];
      out_side.r2   <= s7_r2;
      out_side.bad  <= arg_bad;
    end
  end

endmodule
`default_nettype wire

/* rtl/ucra_sqrt.sv */
`default_nettype none
module ucra_sqrt import ucra_pkg::*; #(
  parameter int RAD_BITS = RAD_W,
  parameter int SIDE_W   = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [RAD_BITS-1:0]   in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_vld,
  output logic [RAD_BITS/2-1:0] out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int RW    = RAD_BITS / 2;
  localparam int REM_W = RW + 2;

  logic              vld  [RW+1];
  logic [RW-1:0]     root [RW+1];
  logic [SIDE_W-1:0] side [RW+1];
  logic [RAD_BITS-1:0] rad [RW];
  logic [REM_W-1:0]  rem  [RW];

  // Entry stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rad[0]  <= in_rad;
      rem[0]  <= '0;
      root[0] <= '0;
      side[0] <= in_side;
    end
  end

  // One root bit per stage: bring down two radicand bits and try the subtract.
  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign shifted = {rem[k][RW-1:0], rad[k][RAD_BITS-1 -: 2]};
    assign trial   = {root[k], 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        root[k+1] <= {root[k][RW-2:0], ge};
        side[k+1] <= side[k];
      end
    end
    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad[k+1] <= rad[k] << 2;
          rem[k+1] <= ge ? shifted - trial : shifted;
        end
      end
    end
  end

  assign out_vld  = vld[RW];
  assign out_root = root[RW];
  assign out_side = side[RW];

endmodule
`default_nettype wire

/* rtl/ucra_div.sv */
`default_nettype none
module ucra_div import ucra_pkg::*; #(
  parameter int NUM_BITS = CNUM_W,
  parameter int DEN_BITS = CDEN_W,
  parameter int Q_BITS   = COEF_W,
  parameter int SIDE_W   = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [NUM_BITS-1:0] in_num,
  input  logic [DEN_BITS-1:0] in_den,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output logic [Q_BITS-1:0]   out_quo,
  output logic [SIDE_W-1:0]   out_side
);

  // The upper dividend bits must be below the divisor, so the quotient
  // fits Q_BITS and the division starts with them as partial remainder.
  logic                vld  [Q_BITS+1];
  logic [Q_BITS-1:0]   quo  [Q_BITS+1];
  logic [SIDE_W-1:0]   side [Q_BITS+1];
  logic [Q_BITS-1:0]   lo   [Q_BITS];
  logic [DEN_BITS-1:0] rem  [Q_BITS];
  logic [DEN_BITS-1:0] den  [Q_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DEN_BITS'(in_num >> Q_BITS);
      lo[0]   <= in_num[Q_BITS-1:0];
      den[0]  <= in_den;
      quo[0]  <= '0;
      side[0] <= in_side;
    end
  end

  // One quotient bit per stage, restoring.
  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    logic [DEN_BITS:0] shifted;
    logic [DEN_BITS:0] diff;
    logic              ge;

    assign shifted = {rem[k], lo[k][Q_BITS-1]};
    assign diff    = shifted - {1'b0, den[k]};
    assign ge      = shifted >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        quo[k+1]  <= {quo[k][Q_BITS-2:0], ge};
        side[k+1] <= side[k];
      end
    end
    if (k < Q_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
          lo[k+1]  <= lo[k] << 1;
          den[k+1] <= den[k];
        end
      end
    end
  end

  assign out_vld  = vld[Q_BITS];
  assign out_quo  = quo[Q_BITS];
  assign out_side = side[Q_BITS];

endmodule
`default_nettype wire

/* rtl/ucra_unproj.sv */
`default_nettype none
module ucra_unproj import ucra_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_vld,
  input  logic [COEF_W-1:0] in_coeff,
  input  side_t             in_side,
  output logic              out_vld,
  output logic [UNP_W-1:0]  out_ux,
  output logic [UNP_W-1:0]  out_uy,
  output logic              out_xs,
  output logic              out_ys,
  output logic              out_bad
);

  logic [2:0] vld;

  logic [COEF_W-1:0] xi12;
  logic [COEF_W:0]   ddiff;
  logic [COEF_W-1:0] u1_den, u2_den, u3_den, u1_coeff;
  logic [NORM_W-1:0] u1_xm, u1_ym;
  logic              u1_xs, u1_ys, u1_bad, u2_xs, u2_ys, u2_bad;
  logic [UPRD_W-1:0] u2_px, u2_py, u3_px, u3_py;
  logic              u3_xs, u3_ys, u3_bad;
  logic [1:0]        xside;
  logic              x_vld, y_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  // Denominator coeff - xi, as magnitude and sign.
  assign xi12  = COEF_W'({cfg.mirror_offset, 12'b0});
  assign ddiff = {1'b0, in_coeff} - {1'b0, xi12};

  always_ff @(posedge clk) begin
    if (en) begin
      u1_den   <= ddiff[COEF_W] ? COEF_W'(-ddiff) : ddiff[COEF_W-1:0];
      u1_xs    <= in_side.xn ^ ddiff[COEF_W];
      u1_ys    <= in_side.yn ^ ddiff[COEF_W];
      u1_bad   <= in_side.bad | (in_coeff == xi12);
      u1_coeff <= in_coeff;
      u1_xm    <= in_side.xm;
      u1_ym    <= in_side.ym;
      // Numerators of the undistorted coordinates.
      u2_px  <= u1_xm * u1_coeff;
      u2_py  <= u1_ym * u1_coeff;
      u2_den <= u1_den;
      u2_xs  <= u1_xs;
      u2_ys  <= u1_ys;
      u2_bad <= u1_bad;
      // A quotient of 2^40 or more means the point leaves the Q12 range.
      u3_px  <= u2_px;
      u3_py  <= u2_py;
      u3_den <= u2_den;
      u3_xs  <= u2_xs;
      u3_ys  <= u2_ys;
      u3_bad <= u2_bad
        | (COEF_W'(u2_px[UPRD_W-1:UNP_W]) >= u2_den)
        | (COEF_W'(u2_py[UPRD_W-1:UNP_W]) >= u2_den);
    end
  end

  ucra_div #(
    .NUM_BITS (UPRD_W),
    .DEN_BITS (COEF_W),
    .Q_BITS   (UNP_W),
    .SIDE_W   (2)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vld[2]),
    .in_num   (u3_px),
    .in_den   (u3_den),
    .in_side  ({u3_xs, u3_bad}),
    .out_vld  (x_vld),
    .out_quo  (out_ux),
    .out_side (xside)
  );

  ucra_div #(
    .NUM_BITS (UPRD_W),
    .DEN_BITS (COEF_W),
    .Q_BITS   (UNP_W),
    .SIDE_W   (1)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vld[2]),
    .in_num   (u3_py),
    .in_den   (u3_den),
    .in_side  (u3_ys),
    .out_vld  (y_vld),
    .out_quo  (out_uy),
    .out_side (out_ys)
  );

  assign out_vld = x_vld & y_vld;
  assign out_xs  = xside[1];
  assign out_bad = xside[0];

endmodule
`default_nettype wire

/* rtl/ucra_back.sv */
`default_nettype none
module ucra_back import ucra_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_vld,
  input  logic [UNP_W-1:0] in_ux,
  input  logic [UNP_W-1:0] in_uy,
  input  logic             in_xs,
  input  logic             in_ys,
  input  logic             in_bad,
  output logic             out_vld,
  output logic [CRD_W-1:0] out_col,
  output logic [CRD_W-1:0] out_row,
  output logic             out_inb
);

  localparam int LIM_FULL = (1 << COORD_BITS) - 1;
  localparam int LIM_I    = (LIM_FULL > 4095) ? 4095 : LIM_FULL;
  localparam logic [CRD_W-1:0] LIM = CRD_W'(LIM_I);

  logic [3:0]  vld;
  logic [55:0] b1_xh, b1_xl, b1_yh, b1_yl;
  logic [56:0] xsum, ysum;
  logic [PRJ_W-1:0] b2_xp, b2_yp;
  logic        b1_xs, b1_ys, b1_bad, b2_xs, b2_ys, b2_bad, b3_bad;
  logic [31:0] xr, yr;
  logic [30:0] b3_xc, b3_yc;
  logic        b3_xneg, b3_yneg;

  // Add the principal point and round to nearest, ties to even.
  // Returns the below-zero flag over the 31-bit coordinate.
  function automatic logic [31:0] round_coord(input logic neg,
                                              input logic [PRJ_W-1:0] p,
                                              input logic [15:0] centre);
    logic signed [46:0] v;
    logic signed [46:0] t;
    logic [30:0]        c;
    v = neg ? $signed({19'b0, centre, 12'b0}) - $signed({2'b0, p})
            : $signed({19'b0, centre, 12'b0}) + $signed({2'b0, p});
    t = v + 47'sh8000;
    c = t[46:16];
    if (v[15:0] == 16'h8000 && c[0]) begin
      c = c - 31'd1;
    end
    return {t[46], c};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_vld};
    end
  end
  assign out_vld = vld[3];

  assign xsum = {1'b0, b1_xh} + 57'(b1_xl[55:16]);
  assign ysum = {1'b0, b1_yh} + 57'(b1_yl[55:16]);
  assign xr   = round_coord(b2_xs, b2_xp, cfg.src_center[15:0]);
  assign yr   = round_coord(b2_ys, b2_yp, cfg.src_center[31:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      // Scale by the source focal lengths in two halves.
      b1_xh  <= cfg.src_fx[31:16] * in_ux;
      b1_xl  <= cfg.src_fx[15:0] * in_ux;
      b1_yh  <= cfg.src_fy[31:16] * in_uy;
      b1_yl  <= cfg.src_fy[15:0] * in_uy;
      b1_xs  <= in_xs;
      b1_ys  <= in_ys;
      b1_bad <= in_bad;
      b2_xp  <= xsum[56:12];
      b2_yp  <= ysum[56:12];
      b2_xs  <= b1_xs;
      b2_ys  <= b1_ys;
      b2_bad <= b1_bad;
      b3_xneg <= xr[31];
      b3_xc   <= xr[30:0];
      b3_yneg <= yr[31];
      b3_yc   <= yr[30:0];
      b3_bad  <= b2_bad;
      // Saturate and check against the image size.
      if (b3_bad) begin
        out_col <= '0;
        out_row <= '0;
        out_inb <= 1'b0;
      end else begin
        out_col <= b3_xneg ? '0 : (b3_xc > 31'(LIM)) ? LIM : b3_xc[CRD_W-1:0];
        out_row <= b3_yneg ? '0 : (b3_yc > 31'(LIM)) ? LIM : b3_yc[CRD_W-1:0];
        out_inb <= !b3_xneg && !b3_yneg
          && (b3_xc < 31'(cfg.src_size[11:0]))
          && (b3_yc < 31'(cfg.src_size[23:12]));
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/unified_camera_remap_address.sv */
`default_nettype none
// Channel   | Direction | Contents
// s_axis    | in        | tdata: dst_col [11:0], dst_row [23:12]
// m_axis    | out       | tdata: src_col [11:0], src_row [23:12]; tuser: in_bounds
// apb       | in/out    | eight 32-bit registers at byte addresses 0x00 to 0x1C
//
// One word is accepted per clock while the output is not held; the pipeline
// holds the 32-step square root and the 33-step and 40-step dividers.
// Reset is synchronous and clears all valid bits and the registers to defaults.
// The whole pipeline advances whenever the output register is empty or being
// taken; when the output is held, s_axis_tready is low and nothing moves.
`include "unified_camera_remap_address_assert.svh"
module unified_camera_remap_address import ucra_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // tdata: dst_col [11:0], dst_row [23:12]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // tdata: src_col [11:0], src_row [23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  // tuser: in_bounds [0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  reg_idx_t ridx;
  logic     en;

  logic              f_vld, s_vld, n_vld, c_vld, u_vld;
  logic [ARGK_W-1:0] f_arg;
  side_t             f_side, s_side, n_side, c_side;
  logic [ROOT_W-1:0] s_root;
  logic [COEF_W-1:0] n_num, c_coeff;
  logic [UNP_W-1:0]  u_ux, u_uy;
  logic              u_xs, u_ys, u_bad;
  logic [CRD_W-1:0]  o_col, o_row;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_inv_fx    <= 32'd21474836;
      cfg.pin_inv_fy    <= 32'd21474836;
      cfg.pin_center    <= '0;
      cfg.src_fx        <= 32'd45875200;
      cfg.src_fy        <= 32'd45875200;
      cfg.src_center    <= '0;
      cfg.mirror_offset <= '0;
      cfg.src_size      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_PIN_INV_FX: cfg.pin_inv_fx    <= pwdata;
        REG_PIN_INV_FY: cfg.pin_inv_fy    <= pwdata;
        REG_PIN_CENTER: cfg.pin_center    <= pwdata;
        REG_SRC_FX:     cfg.src_fx        <= pwdata;
        REG_SRC_FY:     cfg.src_fy        <= pwdata;
        REG_SRC_CENTER: cfg.src_center    <= pwdata;
        REG_MIRROR:     cfg.mirror_offset <= pwdata[XI_W-1:0];
        REG_SRC_SIZE:   cfg.src_size      <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (ridx)
      REG_PIN_INV_FX: prdata = cfg.pin_inv_fx;
      REG_PIN_INV_FY: prdata = cfg.pin_inv_fy;
      REG_PIN_CENTER: prdata = cfg.pin_center;
      REG_SRC_FX:     prdata = cfg.src_fx;
      REG_SRC_FY:     prdata = cfg.src_fy;
      REG_SRC_CENTER: prdata = cfg.src_center;
      REG_MIRROR:     prdata = 32'(cfg.mirror_offset);
      REG_SRC_SIZE:   prdata = 32'(cfg.src_size);
      default:        prdata = '0;
    endcase
  end

  // Global advance: the output register is free or being emptied.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  ucra_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_vld   (s_axis_tvalid),
    .in_col   (s_axis_tdata[11:0]),
    .in_row   (s_axis_tdata[23:12]),
    .out_vld  (f_vld),
    .out_arg  (f_arg),
    .out_side (f_side)
  );

  ucra_sqrt #(
    .RAD_BITS (RAD_W),
    .SIDE_W   ($bits(side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .in_rad   ({f_arg, 28'b0}),
    .in_side  (f_side),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_side (s_side)
  );

  // Numerator xi + root.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (en) begin
      n_vld <= s_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n_num  <= COEF_W'({cfg.mirror_offset, 12'b0}) + COEF_W'(s_root);
      n_side <= s_side;
    end
  end

  // Lifting coefficient: numerator over r2 + 1.
  ucra_div #(
    .NUM_BITS (CNUM_W),
    .DEN_BITS (CDEN_W),
    .Q_BITS   (COEF_W),
    .SIDE_W   ($bits(side_t))
  ) u_coeff_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (n_vld),
    .in_num   ({n_num, 28'b0}),
    .in_den   (CDEN_W'(n_side.r2) + CDEN_W'(Q28_ONE)),
    .in_side  (n_side),
    .out_vld  (c_vld),
    .out_quo  (c_coeff),
    .out_side (c_side)
  );

  ucra_unproj u_unproj (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_vld   (c_vld),
    .in_coeff (c_coeff),
    .in_side  (c_side),
    .out_vld  (u_vld),
    .out_ux   (u_ux),
    .out_uy   (u_uy),
    .out_xs   (u_xs),
    .out_ys   (u_ys),
    .out_bad  (u_bad)
  );

  ucra_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .cfg     (cfg),
    .in_vld  (u_vld),
    .in_ux   (u_ux),
    .in_uy   (u_uy),
    .in_xs   (u_xs),
    .in_ys   (u_ys),
    .in_bad  (u_bad),
    .out_vld (m_axis_tvalid),
    .out_col (o_col),
    .out_row (o_row),
    .out_inb (m_axis_tuser)
  );

  assign m_axis_tdata = {o_row, o_col};

  // A point flagged inside the image lies below the image size.
  `UCRA_ASSERT_NOW(a_inb_col, m_axis_tvalid && m_axis_tuser, o_col < cfg.src_size[11:0])
  `UCRA_ASSERT_NOW(a_inb_row, m_axis_tvalid && m_axis_tuser, o_row < cfg.src_size[23:12])
  // A held output word blocks the input side.
  `UCRA_ASSERT_NOW(a_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule
`default_nettype wire
